// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define VDL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define VDL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/vdl_pkg.sv =====
// Shared widths, constants and register codes of the vertex lighting pipeline.
package vdl_pkg;

    localparam int POS_W   = 32;
    localparam int NRM_W   = 16;
    localparam int COL_W   = 16;
    localparam int DIFF_W  = 33;
    localparam int MAG_W   = 31;
    localparam int NUM_W   = 49;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 34;
    localparam int SQ_STEPS = 32;

    localparam int QW      = 21;
    localparam int COS_DW  = 32;
    localparam int ATT_DW  = 34;
    localparam int NHI_W   = 30;
    localparam int F_W     = 22;

    localparam logic [63:0]       ATT_NUM  = 64'd42949672960;
    localparam logic [ATT_DW-1:0] ATT_K    = 34'd655360;
    localparam logic [ATT_DW-1:0] ATT_REM0 = ATT_DW'(ATT_NUM >> QW);
    localparam logic [QW-1:0]     ATT_FEED = QW'(ATT_NUM);
    localparam logic [QW-1:0]     COS_CAP  = 21'd1048576;
    localparam logic [QW-1:0]     ATT_ONE  = 21'd65536;

    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_LIGHT_X = 3'd0;
    localparam logic [2:0] REG_LIGHT_Y = 3'd1;
    localparam logic [2:0] REG_LIGHT_Z = 3'd2;
    localparam logic [2:0] REG_COL_R   = 3'd3;
    localparam logic [2:0] REG_COL_G   = 3'd4;
    localparam logic [2:0] REG_COL_B   = 3'd5;

endpackage

// ===== hdl/vertex_diffuse_lighting.sv =====
// Top level of the per-vertex diffuse point-light shading pipeline.
// Takes one vertex per clock while the output is not stalled and returns one shaded color per
// vertex, in order: stages 1 to 4 form the light vector, squares and dot product, a row of
// 32 square-root cells yields the distance one bit per cell, a setup stage prepares the
// divides, two rows of 21 division cells run side by side for the cosine term and the
// attenuation, and multiply stages A and B scale the light color. The whole pipe advances
// together; while a finished result is held by a stall on the output, o_in_stall is high.
// Light position and color are read live, so write them only while the pipe is empty.
`include "assert_macros.svh"

module vertex_diffuse_lighting (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [vdl_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [vdl_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [vdl_pkg::POS_W-1:0]   i_pos_z,
    input  logic signed [vdl_pkg::NRM_W-1:0]   i_normal_x,
    input  logic signed [vdl_pkg::NRM_W-1:0]   i_normal_y,
    input  logic signed [vdl_pkg::NRM_W-1:0]   i_normal_z,
    input  logic                               i_last_vertex,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [vdl_pkg::COL_W-1:0]          o_shade_red,
    output logic [vdl_pkg::COL_W-1:0]          o_shade_green,
    output logic [vdl_pkg::COL_W-1:0]          o_shade_blue,
    output logic                               o_batch_end,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vdl_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int SQN = vdl_pkg::SQ_STEPS;
    localparam int QW  = vdl_pkg::QW;

    // Configuration registers
    logic signed [vdl_pkg::POS_W-1:0] r_light_x, r_light_y, r_light_z;
    logic [vdl_pkg::COL_W-1:0]        r_col_r, r_col_g, r_col_b;
    logic                             w_wr;
    logic [2:0]                       w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= '0;
            r_col_r   <= '0;
            r_col_g   <= '0;
            r_col_b   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                vdl_pkg::REG_LIGHT_X: r_light_x <= pwdata;
                vdl_pkg::REG_LIGHT_Y: r_light_y <= pwdata;
                vdl_pkg::REG_LIGHT_Z: r_light_z <= pwdata;
                vdl_pkg::REG_COL_R:   r_col_r   <= pwdata[15:0];
                vdl_pkg::REG_COL_G:   r_col_g   <= pwdata[15:0];
                vdl_pkg::REG_COL_B:   r_col_b   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            vdl_pkg::REG_LIGHT_X: prdata = r_light_x;
            vdl_pkg::REG_LIGHT_Y: prdata = r_light_y;
            vdl_pkg::REG_LIGHT_Z: prdata = r_light_z;
            vdl_pkg::REG_COL_R:   prdata = {16'h0, r_col_r};
            vdl_pkg::REG_COL_G:   prdata = {16'h0, r_col_g};
            vdl_pkg::REG_COL_B:   prdata = {16'h0, r_col_b};
            default:              prdata = '0;
        endcase
    end

    // Pipe advance: hold everything while the output transfer is stalled
    logic w_adv;
    logic r_out_vld;
    assign w_adv      = !r_out_vld || !i_out_stall;
    assign o_in_stall = !w_adv;

    // Stage 1: light minus vertex
    logic                                  r_s1_vld, r_s1_last;
    logic signed [vdl_pkg::DIFF_W-1:0]     r_s1_d [3];
    logic signed [vdl_pkg::NRM_W-1:0]      r_s1_n [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_vld <= 1'b0;
        else if (w_adv) r_s1_vld <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_d[0] <= vdl_pkg::DIFF_W'(r_light_x) - vdl_pkg::DIFF_W'(i_pos_x);
            r_s1_d[1] <= vdl_pkg::DIFF_W'(r_light_y) - vdl_pkg::DIFF_W'(i_pos_y);
            r_s1_d[2] <= vdl_pkg::DIFF_W'(r_light_z) - vdl_pkg::DIFF_W'(i_pos_z);
            r_s1_n[0] <= i_normal_x;
            r_s1_n[1] <= i_normal_y;
            r_s1_n[2] <= i_normal_z;
            r_s1_last <= i_last_vertex;
        end
    end

    // Stage 2: magnitudes, halve all if any is too wide
    logic [vdl_pkg::POS_W-1:0]           w_mag [3];
    logic                                w_s;
    logic                                r_s2_vld, r_s2_last, r_s2_s;
    logic [vdl_pkg::MAG_W-1:0]           r_s2_m [3];
    logic signed [vdl_pkg::POS_W-1:0]    r_s2_c [3];
    logic signed [vdl_pkg::NRM_W-1:0]    r_s2_n [3];
    logic [vdl_pkg::MAG_W-1:0]           w_m [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_s1_d[i][vdl_pkg::DIFF_W-1]
                     ? vdl_pkg::POS_W'(-r_s1_d[i]) : vdl_pkg::POS_W'(r_s1_d[i]);
        end
        w_s = w_mag[0][31] | w_mag[1][31] | w_mag[2][31];
        for (int i = 0; i < 3; i++) begin
            w_m[i] = w_s ? w_mag[i][31:1] : w_mag[i][30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_vld <= 1'b0;
        else if (w_adv) r_s2_vld <= r_s1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_m[i] <= w_m[i];
                r_s2_c[i] <= r_s1_d[i][vdl_pkg::DIFF_W-1]
                           ? -$signed({1'b0, w_m[i]}) : $signed({1'b0, w_m[i]});
                r_s2_n[i] <= r_s1_n[i];
            end
            r_s2_s    <= w_s;
            r_s2_last <= r_s1_last;
        end
    end

    // Stage 3: squares and normal products
    logic                                r_s3_vld, r_s3_last, r_s3_s;
    logic [2*vdl_pkg::MAG_W-1:0]         r_s3_sq [3];
    logic signed [vdl_pkg::NUM_W-1:0]    r_s3_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_vld <= 1'b0;
        else if (w_adv) r_s3_vld <= r_s2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_sq[i] <= r_s2_m[i] * r_s2_m[i];
                r_s3_p[i]  <= vdl_pkg::NUM_W'(r_s2_n[i]) * vdl_pkg::NUM_W'(r_s2_c[i]);
            end
            r_s3_s    <= r_s2_s;
            r_s3_last <= r_s2_last;
        end
    end

    // Stage 4: sum of squares and dot product
    logic                                r_s4_vld, r_s4_last, r_s4_s;
    logic [vdl_pkg::RAD_W-1:0]           r_s4_sum;
    logic signed [vdl_pkg::NUM_W-1:0]    r_s4_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4_vld <= 1'b0;
        else if (w_adv) r_s4_vld <= r_s3_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_sum  <= vdl_pkg::RAD_W'(r_s3_sq[0]) + vdl_pkg::RAD_W'(r_s3_sq[1])
                       + vdl_pkg::RAD_W'(r_s3_sq[2]);
            r_s4_num  <= r_s3_p[0] + r_s3_p[1] + r_s3_p[2];
            r_s4_s    <= r_s3_s;
            r_s4_last <= r_s3_last;
        end
    end

    // Square root row
    logic [vdl_pkg::RAD_W-1:0]           w_sq_rad  [SQN];
    logic [vdl_pkg::REM_W-1:0]           w_sq_rem  [SQN];
    logic [vdl_pkg::ROOT_W-1:0]          w_sq_root [SQN];
    logic                                r_sq_vld  [SQN];
    logic                                r_sq_last [SQN];
    logic                                r_sq_s    [SQN];
    logic signed [vdl_pkg::NUM_W-1:0]    r_sq_num  [SQN];

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        if (k == 0) begin : g_head
            vdl_sqrt_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_adv),
                .i_rad  (r_s4_sum),
                .i_rem  ('0),
                .i_root ('0),
                .o_rad  (w_sq_rad[k]),
                .o_rem  (w_sq_rem[k]),
                .o_root (w_sq_root[k])
            );
        end else begin : g_body
            vdl_sqrt_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_adv),
                .i_rad  (w_sq_rad[k-1]),
                .i_rem  (w_sq_rem[k-1]),
                .i_root (w_sq_root[k-1]),
                .o_rad  (w_sq_rad[k]),
                .o_rem  (w_sq_rem[k]),
                .o_root (w_sq_root[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQN; k++) r_sq_vld[k] <= 1'b0;
        end else if (w_adv) begin
            r_sq_vld[0] <= r_s4_vld;
            for (int k = 1; k < SQN; k++) r_sq_vld[k] <= r_sq_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_last[0] <= r_s4_last;
            r_sq_s[0]    <= r_s4_s;
            r_sq_num[0]  <= r_s4_num;
            for (int k = 1; k < SQN; k++) begin
                r_sq_last[k] <= r_sq_last[k-1];
                r_sq_s[k]    <= r_sq_s[k-1];
                r_sq_num[k]  <= r_sq_num[k-1];
            end
        end
    end

    // Divide setup: cosine numerator 4*num over len_s, attenuation over K + len
    logic [vdl_pkg::ROOT_W-1:0]          w_lens;
    logic signed [vdl_pkg::NUM_W-1:0]    w_num;
    logic [vdl_pkg::NUM_W+1:0]           w_n4;
    logic [vdl_pkg::ROOT_W:0]            w_len;
    logic                                r_p_vld, r_p_last, r_p_zero, r_p_ovf;
    logic [vdl_pkg::COS_DW-1:0]          r_p_lens, r_p_nhi;
    logic [QW-1:0]                       r_p_nlo;
    logic [vdl_pkg::ATT_DW-1:0]          r_p_d2;

    assign w_lens = w_sq_root[SQN-1];
    assign w_num  = r_sq_num[SQN-1];
    assign w_n4   = {w_num, 2'b00};
    assign w_len  = r_sq_s[SQN-1] ? {w_lens, 1'b0} : {1'b0, w_lens};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p_vld <= 1'b0;
        else if (w_adv) r_p_vld <= r_sq_vld[SQN-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_last <= r_sq_last[SQN-1];
            r_p_zero <= (w_lens == '0) || w_num[vdl_pkg::NUM_W-1] || (w_num == '0);
            r_p_lens <= w_lens;
            r_p_nhi  <= vdl_pkg::COS_DW'(w_n4[vdl_pkg::NUM_W+1:QW]);
            r_p_ovf  <= vdl_pkg::COS_DW'(w_n4[vdl_pkg::NUM_W+1:QW]) >= w_lens;
            r_p_nlo  <= w_n4[QW-1:0];
            r_p_d2   <= vdl_pkg::ATT_K + vdl_pkg::ATT_DW'(w_len);
        end
    end

    // Division rows, cosine and attenuation in step
    logic [vdl_pkg::COS_DW-1:0] w_cd_d [QW], w_cd_rem [QW];
    logic [QW-1:0]              w_cd_feed [QW], w_cd_q [QW];
    logic [vdl_pkg::ATT_DW-1:0] w_ad_d [QW], w_ad_rem [QW];
    logic [QW-1:0]              w_ad_feed [QW], w_ad_q [QW];
    logic                       r_dv_vld [QW], r_dv_last [QW], r_dv_zero [QW], r_dv_ovf [QW];

    for (genvar k = 0; k < QW; k++) begin : g_div
        if (k == 0) begin : g_head
            vdl_div_cell #(.W(vdl_pkg::COS_DW)) u_cos (
                .i_clk(i_clk), .i_en(w_adv),
                .i_d(r_p_lens), .i_rem(r_p_nhi), .i_feed(r_p_nlo), .i_q('0),
                .o_d(w_cd_d[k]), .o_rem(w_cd_rem[k]), .o_feed(w_cd_feed[k]), .o_q(w_cd_q[k])
            );
            vdl_div_cell #(.W(vdl_pkg::ATT_DW)) u_att (
                .i_clk(i_clk), .i_en(w_adv),
                .i_d(r_p_d2), .i_rem(vdl_pkg::ATT_REM0), .i_feed(vdl_pkg::ATT_FEED),
                .i_q('0),
                .o_d(w_ad_d[k]), .o_rem(w_ad_rem[k]), .o_feed(w_ad_feed[k]), .o_q(w_ad_q[k])
            );
        end else begin : g_body
            vdl_div_cell #(.W(vdl_pkg::COS_DW)) u_cos (
                .i_clk(i_clk), .i_en(w_adv),
                .i_d(w_cd_d[k-1]), .i_rem(w_cd_rem[k-1]), .i_feed(w_cd_feed[k-1]),
                .i_q(w_cd_q[k-1]),
                .o_d(w_cd_d[k]), .o_rem(w_cd_rem[k]), .o_feed(w_cd_feed[k]), .o_q(w_cd_q[k])
            );
            vdl_div_cell #(.W(vdl_pkg::ATT_DW)) u_att (
                .i_clk(i_clk), .i_en(w_adv),
                .i_d(w_ad_d[k-1]), .i_rem(w_ad_rem[k-1]), .i_feed(w_ad_feed[k-1]),
                .i_q(w_ad_q[k-1]),
                .o_d(w_ad_d[k]), .o_rem(w_ad_rem[k]), .o_feed(w_ad_feed[k]), .o_q(w_ad_q[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) r_dv_vld[k] <= 1'b0;
        end else if (w_adv) begin
            r_dv_vld[0] <= r_p_vld;
            for (int k = 1; k < QW; k++) r_dv_vld[k] <= r_dv_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_last[0] <= r_p_last;
            r_dv_zero[0] <= r_p_zero;
            r_dv_ovf[0]  <= r_p_ovf;
            for (int k = 1; k < QW; k++) begin
                r_dv_last[k] <= r_dv_last[k-1];
                r_dv_zero[k] <= r_dv_zero[k-1];
                r_dv_ovf[k]  <= r_dv_ovf[k-1];
            end
        end
    end

    // Stage A: cap cosine, multiply by attenuation
    logic [QW-1:0]               w_cos_q, w_att_q, w_cos;
    logic [QW+16:0]              w_fprod;
    logic                        r_a_vld, r_a_last, r_a_zero;
    logic [vdl_pkg::F_W-1:0]     r_a_f;

    assign w_cos_q = w_cd_q[QW-1];
    assign w_att_q = w_ad_q[QW-1];
    assign w_cos   = (r_dv_ovf[QW-1] || (w_cos_q > vdl_pkg::COS_CAP)) ? vdl_pkg::COS_CAP
                                                                      : w_cos_q;
    assign w_fprod = w_cos * w_att_q[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else if (w_adv) r_a_vld <= r_dv_vld[QW-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_f    <= w_fprod[QW+16:16];
            r_a_last <= r_dv_last[QW-1];
            r_a_zero <= r_dv_zero[QW-1];
        end
    end

    // Stage B: scale color, saturate, output register
    function automatic logic [vdl_pkg::COL_W-1:0] scale_sat(
        input logic [vdl_pkg::COL_W-1:0] col,
        input logic [vdl_pkg::F_W-1:0]   f
    );
        logic [vdl_pkg::COL_W+vdl_pkg::F_W-1:0] prod;
        prod = col * f;
        return (|prod[vdl_pkg::COL_W+vdl_pkg::F_W-1:32]) ? '1 : prod[31:16];
    endfunction

    logic [vdl_pkg::COL_W-1:0] r_out_r, r_out_g, r_out_b;
    logic                      r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (w_adv) r_out_vld <= r_a_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_r    <= r_a_zero ? '0 : scale_sat(r_col_r, r_a_f);
            r_out_g    <= r_a_zero ? '0 : scale_sat(r_col_g, r_a_f);
            r_out_b    <= r_a_zero ? '0 : scale_sat(r_col_b, r_a_f);
            r_out_last <= r_a_last;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_shade_red   = r_out_r;
    assign o_shade_green = r_out_g;
    assign o_shade_blue  = r_out_b;
    assign o_batch_end   = r_out_last;

    `VDL_ASSERT(a_hold_input, i_clk, i_rst_n, (r_out_vld && i_out_stall) |-> o_in_stall, "input taken while output held")
    `VDL_ASSERT(a_att_range, i_clk, i_rst_n, r_dv_vld[QW-1] |-> (w_att_q <= vdl_pkg::ATT_ONE), "attenuation above one")
    `VDL_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

// ===== hdl/vdl_sqrt_cell.sv =====
// One digit step of the integer square root: two radicand bits in, one root bit out.
module vdl_sqrt_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [vdl_pkg::RAD_W-1:0]   i_rad,
    input  logic [vdl_pkg::REM_W-1:0]   i_rem,
    input  logic [vdl_pkg::ROOT_W-1:0]  i_root,
    output logic [vdl_pkg::RAD_W-1:0]   o_rad,
    output logic [vdl_pkg::REM_W-1:0]   o_rem,
    output logic [vdl_pkg::ROOT_W-1:0]  o_root
);

    logic [vdl_pkg::REM_W+1:0]  w_t;
    logic [vdl_pkg::REM_W+1:0]  w_trial;
    logic                       w_take;
    logic [vdl_pkg::RAD_W-1:0]  r_rad, n_rad;
    logic [vdl_pkg::REM_W-1:0]  r_rem, n_rem;
    logic [vdl_pkg::ROOT_W-1:0] r_root, n_root;

    assign w_t     = {i_rem, i_rad[vdl_pkg::RAD_W-1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_take  = (w_t >= w_trial);

    always_comb begin
        n_rad  = {i_rad[vdl_pkg::RAD_W-3:0], 2'b00};
        n_root = {i_root[vdl_pkg::ROOT_W-2:0], w_take};
        n_rem  = w_take ? vdl_pkg::REM_W'(w_t - w_trial) : w_t[vdl_pkg::REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== hdl/vdl_div_cell.sv =====
// One restoring division step: shift in a dividend bit, compare, subtract, emit a quotient bit.
module vdl_div_cell #(
    parameter int W = vdl_pkg::COS_DW
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [W-1:0]            i_d,
    input  logic [W-1:0]            i_rem,
    input  logic [vdl_pkg::QW-1:0]  i_feed,
    input  logic [vdl_pkg::QW-1:0]  i_q,
    output logic [W-1:0]            o_d,
    output logic [W-1:0]            o_rem,
    output logic [vdl_pkg::QW-1:0]  o_feed,
    output logic [vdl_pkg::QW-1:0]  o_q
);

    logic [W:0]                w_t;
    logic [W:0]                w_dx;
    logic                      w_take;
    logic [W-1:0]              r_d, r_rem, n_rem;
    logic [vdl_pkg::QW-1:0]    r_feed, r_q, n_feed, n_q;

    assign w_t    = {i_rem, i_feed[vdl_pkg::QW-1]};
    assign w_dx   = {1'b0, i_d};
    assign w_take = (w_t >= w_dx);

    always_comb begin
        n_rem  = w_take ? W'(w_t - w_dx) : w_t[W-1:0];
        n_q    = {i_q[vdl_pkg::QW-2:0], w_take};
        n_feed = {i_feed[vdl_pkg::QW-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= i_d;
            r_rem  <= n_rem;
            r_feed <= n_feed;
            r_q    <= n_q;
        end
    end

    assign o_d    = r_d;
    assign o_rem  = r_rem;
    assign o_feed = r_feed;
    assign o_q    = r_q;

endmodule
